// File: hdl/dds_pkg.sv
// ----------------------------------------------------------------------------
// dds_pkg
// Shared constants, codes and controller/datapath command types for the
// delimited decimal sum block.
// ----------------------------------------------------------------------------
package dds_pkg;

  // Default width of the running total
  localparam int SUM_BITS_DEF = 32;

  // ASCII codes the parser and the formatter care about
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_HT    = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  // Field parse phases
  localparam logic [1:0] PH_SPACE  = 2'd0;
  localparam logic [1:0] PH_DIGITS = 2'd1;
  localparam logic [1:0] PH_DONE   = 2'd2;

  // Decimal digits needed for an unsigned value of the given width
  function automatic int dec_digits(input int bits);
    dec_digits = (bits * 30103) / 100000 + 1;
  endfunction

  // Commands from the controller to the datapath
  typedef struct packed {
    logic take_byte;    // parse one accepted message byte
    logic close_field;  // add the open field into the total
    logic load_conv;    // latch magnitude and sign, clear total and parse state
    logic conv_step;    // one binary to BCD shift-add-3 step
    logic shift_digit;  // drop the leading BCD digit
    logic show_sign;    // present a minus sign on the output
  } dds_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic top_zero;     // leading BCD digit is zero
    logic neg;          // latched total is negative
  } dds_sts_t;

endpackage

// File: hdl/dds_in_if.sv
// ----------------------------------------------------------------------------
// dds_in_if
// Valid/ready channel carrying one message byte and its end-of-message flag.
// ----------------------------------------------------------------------------
interface dds_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_byte;
  logic       end_of_message;

  modport source (output valid, output char_byte, output end_of_message, input ready);
  modport sink   (input valid, input char_byte, input end_of_message, output ready);
endinterface

// File: hdl/dds_out_if.sv
// ----------------------------------------------------------------------------
// dds_out_if
// Valid/ready channel carrying one character of the decimal sum.
// ----------------------------------------------------------------------------
interface dds_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] sum_char;
  logic       final_char;

  modport source (output valid, output sum_char, output final_char, input ready);
  modport sink   (input valid, input sum_char, input final_char, output ready);
endinterface

// File: hdl/delimited_decimal_sum.sv
// ----------------------------------------------------------------------------
// delimited_decimal_sum
// Sums the colon-separated signed decimal fields of a byte stream message and
// returns the total as ASCII decimal text.
// ----------------------------------------------------------------------------
// Throughput: one message byte per cycle until the byte flagged last.
// After the last byte: close of the open field, converter load and shift-add-3
//   BCD conversion, then leading zero trim, then one character per cycle
//   while ready.
// Input is held off from the last byte until the final character transfers.
// Reset: synchronous rst clears the total, the field parser and the sequencer.
module delimited_decimal_sum
  import dds_pkg::*;
#(
  parameter int SUM_BITS = SUM_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst,
  dds_in_if.sink    in_ch,
  dds_out_if.source out_ch
);

  dds_cmd_t cmd;
  dds_sts_t sts;

  dds_ctrl #(
    .SUM_BITS (SUM_BITS)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_ch.valid),
    .in_last   (in_ch.end_of_message),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_final (out_ch.final_char),
    .sts       (sts),
    .cmd       (cmd)
  );

  dds_datapath #(
    .SUM_BITS (SUM_BITS)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .char_byte (in_ch.char_byte),
    .sts       (sts),
    .sum_char  (out_ch.sum_char)
  );

endmodule

// File: hdl/dds_datapath.sv
// ----------------------------------------------------------------------------
// dds_datapath
// Field parser, running total, binary to BCD converter and digit shifter.
// ----------------------------------------------------------------------------
module dds_datapath
  import dds_pkg::*;
#(
  parameter int SUM_BITS = SUM_BITS_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  dds_cmd_t         cmd,
  input  logic [7:0]       char_byte,
  output dds_sts_t         sts,
  output logic [7:0]       sum_char
);

  localparam int NumDigits = dec_digits(SUM_BITS);
  localparam int BcdBits   = NumDigits * 4;

  logic [SUM_BITS-1:0] total;
  logic [SUM_BITS-1:0] field;
  logic                field_neg;
  logic [1:0]          phase;
  logic                text_ended;
  logic [SUM_BITS-1:0] mag;
  logic [BcdBits-1:0]  bcd;
  logic                neg;

  logic [SUM_BITS-1:0] field_signed;
  logic [SUM_BITS-1:0] total_closed;
  logic [SUM_BITS-1:0] field_next;
  logic [1:0]          phase_next;
  logic                field_neg_next;
  logic                is_blank;
  logic                is_digit;
  logic [3:0]          digit_val;
  logic [BcdBits-1:0]  bcd_adj;
  logic [3:0]          top_digit;

  // Close value: signed field added into the total
  assign field_signed = field_neg ? (~field + SUM_BITS'(1)) : field;
  assign total_closed = total + field_signed;

  assign is_blank  = (char_byte == CH_SPACE) ||
                     ((char_byte >= CH_HT) && (char_byte <= CH_CR));
  assign is_digit  = (char_byte >= CH_ZERO) && (char_byte <= CH_NINE);
  assign digit_val = char_byte[3:0];

  // Parse one non-delimiter byte against the current phase
  always_comb begin
    field_next     = field;
    phase_next     = phase;
    field_neg_next = field_neg;
    if (phase == PH_SPACE) begin
      if (is_blank) begin
        phase_next = PH_SPACE;
      end else if ((char_byte == CH_MINUS) || (char_byte == CH_PLUS)) begin
        field_neg_next = (char_byte == CH_MINUS);
        phase_next     = PH_DIGITS;
      end else if (is_digit) begin
        field_next = (field << 3) + (field << 1) + SUM_BITS'(digit_val);
        phase_next = PH_DIGITS;
      end else begin
        phase_next = PH_DONE;
      end
    end else if (phase == PH_DIGITS) begin
      if (is_digit) begin
        field_next = (field << 3) + (field << 1) + SUM_BITS'(digit_val);
      end else begin
        phase_next = PH_DONE;
      end
    end
  end

  // Add 3 to every BCD digit of five or more before the shift
  always_comb begin
    for (int d = 0; d < NumDigits; d++) begin
      bcd_adj[d*4 +: 4] = (bcd[d*4 +: 4] >= 4'd5) ? (bcd[d*4 +: 4] + 4'd3) : bcd[d*4 +: 4];
    end
  end

  // Hold parser and total state
  always_ff @(posedge clk) begin
    if (rst) begin
      total      <= '0;
      field      <= '0;
      field_neg  <= 1'b0;
      phase      <= PH_SPACE;
      text_ended <= 1'b0;
    end else if (cmd.load_conv) begin
      total      <= '0;
      field      <= '0;
      field_neg  <= 1'b0;
      phase      <= PH_SPACE;
      text_ended <= 1'b0;
    end else if (cmd.close_field) begin
      total     <= total_closed;
      field     <= '0;
      field_neg <= 1'b0;
      phase     <= PH_SPACE;
    end else if (cmd.take_byte && !text_ended) begin
      if (char_byte == CH_NUL) begin
        text_ended <= 1'b1;
      end else if (char_byte == CH_COLON) begin
        total     <= total_closed;
        field     <= '0;
        field_neg <= 1'b0;
        phase     <= PH_SPACE;
      end else begin
        field     <= field_next;
        field_neg <= field_neg_next;
        phase     <= phase_next;
      end
    end
  end

  // Convert the magnitude to BCD and shift digits out
  always_ff @(posedge clk) begin
    if (cmd.load_conv) begin
      neg <= total[SUM_BITS-1];
      mag <= total[SUM_BITS-1] ? (~total + SUM_BITS'(1)) : total;
      bcd <= '0;
    end else if (cmd.conv_step) begin
      bcd <= {bcd_adj[BcdBits-2:0], mag[SUM_BITS-1]};
      mag <= {mag[SUM_BITS-2:0], 1'b0};
    end else if (cmd.shift_digit) begin
      bcd <= {bcd[BcdBits-5:0], 4'd0};
    end
  end

  assign top_digit    = bcd[BcdBits-1 -: 4];
  assign sts.top_zero = (top_digit == 4'd0);
  assign sts.neg      = neg;
  assign sum_char     = cmd.show_sign ? CH_MINUS : (CH_ZERO + {4'd0, top_digit});

endmodule

// File: hdl/dds_ctrl.sv
// ----------------------------------------------------------------------------
// dds_ctrl
// Sequencer: accepts message bytes, then runs close, conversion, leading
// zero trim and character output.
// ----------------------------------------------------------------------------
module dds_ctrl
  import dds_pkg::*;
#(
  parameter int SUM_BITS = SUM_BITS_DEF
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  input  logic     in_last,
  output logic     in_ready,
  output logic     out_valid,
  input  logic     out_ready,
  output logic     out_final,
  input  dds_sts_t sts,
  output dds_cmd_t cmd
);

  localparam int NumDigits = dec_digits(SUM_BITS);
  localparam int BitW      = $clog2(SUM_BITS + 1);
  localparam int DigW      = $clog2(NumDigits + 1);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_CLOSE = 3'd1;
  localparam logic [2:0] S_LOAD  = 3'd2;
  localparam logic [2:0] S_CONV  = 3'd3;
  localparam logic [2:0] S_TRIM  = 3'd4;
  localparam logic [2:0] S_SIGN  = 3'd5;
  localparam logic [2:0] S_DIGIT = 3'd6;

  logic [2:0]      state, state_next;
  logic [BitW-1:0] bit_cnt, bit_cnt_next;
  logic [DigW-1:0] dig_left, dig_left_next;

  assign in_ready  = (state == S_IDLE);
  assign out_valid = (state == S_SIGN) || (state == S_DIGIT);
  assign out_final = (state == S_DIGIT) && (dig_left == DigW'(1));

  // Decide next state and issue datapath commands
  always_comb begin
    state_next    = state;
    bit_cnt_next  = bit_cnt;
    dig_left_next = dig_left;
    cmd           = '0;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.take_byte = 1'b1;
          if (in_last) state_next = S_CLOSE;
        end
      end
      S_CLOSE: begin
        cmd.close_field = 1'b1;
        state_next      = S_LOAD;
      end
      S_LOAD: begin
        cmd.load_conv = 1'b1;
        bit_cnt_next  = BitW'(SUM_BITS);
        state_next    = S_CONV;
      end
      S_CONV: begin
        cmd.conv_step = 1'b1;
        bit_cnt_next  = bit_cnt - BitW'(1);
        if (bit_cnt == BitW'(1)) begin
          dig_left_next = DigW'(NumDigits);
          state_next    = S_TRIM;
        end
      end
      S_TRIM: begin
        if (sts.top_zero && (dig_left > DigW'(1))) begin
          cmd.shift_digit = 1'b1;
          dig_left_next   = dig_left - DigW'(1);
        end else begin
          state_next = sts.neg ? S_SIGN : S_DIGIT;
        end
      end
      S_SIGN: begin
        cmd.show_sign = 1'b1;
        if (out_ready) state_next = S_DIGIT;
      end
      S_DIGIT: begin
        if (out_ready) begin
          if (dig_left == DigW'(1)) begin
            state_next = S_IDLE;
          end else begin
            cmd.shift_digit = 1'b1;
            dig_left_next   = dig_left - DigW'(1);
          end
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Advance state and counters
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      bit_cnt  <= '0;
      dig_left <= '0;
    end else begin
      state    <= state_next;
      bit_cnt  <= bit_cnt_next;
      dig_left <= dig_left_next;
    end
  end

endmodule
